// ===== rtl/rcpf_pkg.sv =====
package rcpf_pkg;

   // Field widths fixed by the interface.
   localparam int PULSE_W    = 12;
   localparam int TIMEOUT_W  = 24;
   localparam int TICK_W     = 32;
   localparam int TIME_W     = 48;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Number of representable pulse widths; bounds every accepted width.
   localparam int PULSE_RANGE = 2 ** PULSE_W;

   // Fixed channel roles.
   localparam int CH_STEERING = 0;
   localparam int CH_THROTTLE = 1;
   localparam int CH_MODE     = 2;

   // Register reset values.
   localparam logic [PULSE_W-1:0]   RST_MIN_PULSE       = 12'd800;
   localparam logic [PULSE_W-1:0]   RST_MAX_PULSE       = 12'd2200;
   localparam logic [PULSE_W-1:0]   RST_CENTER          = 12'd1500;
   localparam logic [TIMEOUT_W-1:0] RST_SIGNAL_TIMEOUT  = 24'd500000;
   localparam logic [TIMEOUT_W-1:0] RST_COMMAND_TIMEOUT = 24'd500000;

   typedef enum logic [1:0] {
      OP_CAPTURE = 2'd0,
      OP_COMMAND = 2'd1,
      OP_QUERY   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      MODE_MANUAL     = 2'd0,
      MODE_AUTONOMOUS = 2'd1,
      MODE_FAILSAFE   = 2'd2
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_PULSE       = 3'd0,
      CSR_MAX_PULSE       = 3'd1,
      CSR_CENTER          = 3'd2,
      CSR_SIGNAL_TIMEOUT  = 3'd3,
      CSR_COMMAND_TIMEOUT = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [PULSE_W-1:0]   min_pulse_us;
      logic [PULSE_W-1:0]   max_pulse_us;
      logic [PULSE_W-1:0]   center_us;
      logic [TIMEOUT_W-1:0] signal_timeout_us;
      logic [TIMEOUT_W-1:0] command_timeout_us;
   } cfg_type;

   // One request word as it enters the pipeline.
   typedef struct packed {
      logic [1:0]        op;
      logic [1:0]        channel;
      logic              rising;
      logic [TICK_W-1:0] capture_ticks;
      logic [TIME_W-1:0] now_us;
   } item_type;

   // Capture stage to window stage.
   typedef struct packed {
      logic              falling;
      logic              is_command;
      logic [1:0]        channel;
      logic [TICK_W-1:0] delta;
      logic [TIME_W-1:0] now_us;
   } capture_type;

   // Window stage to status stage.
   typedef struct packed {
      logic              keep;
      logic              is_command;
      logic [1:0]        channel;
      logic [TIME_W-1:0] now_us;
   } update_type;

   typedef struct packed {
      logic [PULSE_W-1:0] steering_us;
      logic [PULSE_W-1:0] throttle_us;
      logic               manual_switch;
      logic               link_ok;
      mode_type           drive_mode;
   } result_type;

endpackage

// ===== rtl/rcpf_req_if.sv =====
interface rcpf_req_if;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 op;
   logic [1:0]                 channel;
   logic                       rising;
   logic [rcpf_pkg::TICK_W-1:0] capture_ticks;
   logic [rcpf_pkg::TIME_W-1:0] now_us;

   modport source (output valid, op, channel, rising, capture_ticks, now_us, input ready);
   modport sink (input valid, op, channel, rising, capture_ticks, now_us, output ready);
endinterface

// ===== rtl/rcpf_rsp_if.sv =====
interface rcpf_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rcpf_pkg::PULSE_W-1:0] steering_us;
   logic [rcpf_pkg::PULSE_W-1:0] throttle_us;
   logic                         manual_switch;
   logic                         link_ok;
   logic [1:0]                   drive_mode;

   modport source (output valid, steering_us, throttle_us, manual_switch, link_ok,
                   drive_mode, input ready);
   modport sink (input valid, steering_us, throttle_us, manual_switch, link_ok,
                 drive_mode, output ready);
endinterface

// ===== rtl/rcpf_capture.sv =====
module rcpf_capture #(
   parameter int NUM_CHANNELS = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic                   advance,
   input  rcpf_pkg::item_type     item,
   output rcpf_pkg::capture_type  cap
);

   localparam int CH_W = $clog2(NUM_CHANNELS);

   rcpf_pkg::item_type                item_ff;
   logic [rcpf_pkg::TICK_W-1:0]       rise_count_ff [NUM_CHANNELS];
   logic [rcpf_pkg::TICK_W-1:0]       rise_count_in [NUM_CHANNELS];
   logic                              ch_ok;
   logic [CH_W-1:0]                   idx;
   logic                              is_capture;
   logic [rcpf_pkg::TICK_W-1:0]       rise_rd;

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
   end

   assign ch_ok      = 32'(item_ff.channel) < 32'(NUM_CHANNELS);
   assign idx        = CH_W'(item_ff.channel);
   assign is_capture = (item_ff.op == rcpf_pkg::OP_CAPTURE) && ch_ok;
   assign rise_rd    = ch_ok ? rise_count_ff[idx] : '0;

   // A rising edge overwrites the channel's start count once the word moves on.
   always_comb begin
      rise_count_in = rise_count_ff;
      if (advance && is_capture && item_ff.rising) begin
         rise_count_in[idx] = item_ff.capture_ticks;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            rise_count_ff[i] <= '0;
         end
      end else begin
         rise_count_ff <= rise_count_in;
      end
   end

   always_comb begin
      cap.falling    = is_capture && !item_ff.rising;
      cap.is_command = item_ff.op == rcpf_pkg::OP_COMMAND;
      cap.channel    = item_ff.channel;
      cap.delta      = item_ff.capture_ticks - rise_rd;
      cap.now_us     = item_ff.now_us;
   end

endmodule

// ===== rtl/rcpf_window.sv =====
module rcpf_window #(
   parameter  int TICKS_PER_US = 80,
   localparam int DELTA_W      = $clog2(rcpf_pkg::PULSE_RANGE * TICKS_PER_US),
   localparam int RECIP_W      = DELTA_W + 2,
   localparam int PROD_W       = DELTA_W + RECIP_W
) (
   input  logic                  clock,
   input  logic                  load,
   input  rcpf_pkg::capture_type cap,
   input  rcpf_pkg::cfg_type     cfg,
   output rcpf_pkg::update_type  upd,
   output logic [PROD_W-1:0]     prod
);

   localparam int     THR_W = DELTA_W + 1;
   localparam int     SHIFT = DELTA_W + $clog2(TICKS_PER_US);
   // Rounded-up reciprocal; exact floor division for any DELTA_W-bit count.
   localparam longint RECIP = ((longint'(1) <<< SHIFT) + TICKS_PER_US - 1) / TICKS_PER_US;

   rcpf_pkg::capture_type cap_ff;
   logic [THR_W-1:0]      lo_ff;
   logic [THR_W-1:0]      hi_ff;
   logic [THR_W-1:0]      lo_in;
   logic [THR_W-1:0]      hi_in;

   // The window is kept in ticks: min*T <= delta < (max+1)*T.
   assign lo_in = THR_W'(cfg.min_pulse_us) * THR_W'(TICKS_PER_US);
   assign hi_in = (THR_W'(cfg.max_pulse_us) + THR_W'(1)) * THR_W'(TICKS_PER_US);

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      if (load) begin
         cap_ff <= cap;
      end
   end

   always_comb begin
      upd.keep       = cap_ff.falling
                       && (cap_ff.delta >= rcpf_pkg::TICK_W'(lo_ff))
                       && (cap_ff.delta <  rcpf_pkg::TICK_W'(hi_ff));
      upd.is_command = cap_ff.is_command;
      upd.channel    = cap_ff.channel;
      upd.now_us     = cap_ff.now_us;
   end

   // Only meaningful when the width is kept, and then delta fits DELTA_W bits.
   assign prod = PROD_W'(cap_ff.delta[DELTA_W-1:0]) * PROD_W'(RECIP_W'(RECIP));

endmodule

// ===== rtl/rcpf_status.sv =====
module rcpf_status #(
   parameter  int NUM_CHANNELS = 3,
   parameter  int TICKS_PER_US = 80,
   localparam int DELTA_W      = $clog2(rcpf_pkg::PULSE_RANGE * TICKS_PER_US),
   localparam int PROD_W       = 2 * DELTA_W + 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic                 advance,
   input  rcpf_pkg::update_type upd,
   input  logic [PROD_W-1:0]    prod,
   input  rcpf_pkg::cfg_type    cfg,
   output rcpf_pkg::result_type result
);

   localparam int CH_W  = $clog2(NUM_CHANNELS);
   localparam int SHIFT = DELTA_W + $clog2(TICKS_PER_US);

   rcpf_pkg::update_type            upd_ff;
   logic [PROD_W-1:0]               prod_ff;
   logic [rcpf_pkg::PULSE_W-1:0]    width;
   logic [CH_W-1:0]                 idx;
   logic                            keep_now;
   logic                            command_now;

   logic [rcpf_pkg::PULSE_W-1:0]    pulse_width_ff  [NUM_CHANNELS];
   logic [rcpf_pkg::PULSE_W-1:0]    pulse_width_in  [NUM_CHANNELS];
   logic [rcpf_pkg::TIME_W-1:0]     edge_time_ff    [NUM_CHANNELS];
   logic [rcpf_pkg::TIME_W-1:0]     edge_time_in    [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0]         edge_seen_ff;
   logic [NUM_CHANNELS-1:0]         edge_seen_in;
   logic [rcpf_pkg::TIME_W-1:0]     command_time_ff;
   logic [rcpf_pkg::TIME_W-1:0]     command_time_in;
   logic                            command_seen_ff;
   logic                            command_seen_in;
   logic [NUM_CHANNELS-1:0]         fresh;
   logic [rcpf_pkg::TIME_W-1:0]     command_age;
   logic                            manual;
   logic                            sig_ok;

   always_ff @(posedge clock) begin
      if (load) begin
         upd_ff  <= upd;
         prod_ff <= prod;
      end
   end

   assign width       = rcpf_pkg::PULSE_W'(prod_ff >> SHIFT);
   assign idx         = CH_W'(upd_ff.channel);
   assign keep_now    = advance && upd_ff.keep;
   assign command_now = advance && upd_ff.is_command;

   always_comb begin
      pulse_width_in  = pulse_width_ff;
      edge_time_in    = edge_time_ff;
      edge_seen_in    = edge_seen_ff;
      command_time_in = command_time_ff;
      command_seen_in = command_seen_ff;
      if (keep_now) begin
         pulse_width_in[idx] = width;
         edge_time_in[idx]   = upd_ff.now_us;
         edge_seen_in[idx]   = 1'b1;
      end
      if (command_now) begin
         command_time_in = upd_ff.now_us;
         command_seen_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      edge_time_ff    <= edge_time_in;
      command_time_ff <= command_time_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            pulse_width_ff[i] <= rcpf_pkg::RST_CENTER;
         end
         edge_seen_ff    <= '0;
         command_seen_ff <= 1'b0;
      end else begin
         pulse_width_ff  <= pulse_width_in;
         edge_seen_ff    <= edge_seen_in;
         command_seen_ff <= command_seen_in;
      end
   end

   // Ages wrap modulo 2^48, so a plain subtraction at full width is the age.
   always_comb begin
      logic [rcpf_pkg::TIME_W-1:0] age;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         age      = upd_ff.now_us - edge_time_in[i];
         fresh[i] = edge_seen_in[i]
                    && (age < rcpf_pkg::TIME_W'(cfg.signal_timeout_us));
      end
   end

   assign command_age = upd_ff.now_us - command_time_in;
   assign manual      = pulse_width_in[rcpf_pkg::CH_MODE] > cfg.center_us;
   assign sig_ok      = |fresh;

   always_comb begin
      result.steering_us   = pulse_width_in[rcpf_pkg::CH_STEERING];
      result.throttle_us   = pulse_width_in[rcpf_pkg::CH_THROTTLE];
      result.manual_switch = manual;
      result.link_ok       = sig_ok;
      if (manual && sig_ok) begin
         result.drive_mode = rcpf_pkg::MODE_MANUAL;
      end else if (!command_seen_in
                   || (command_age > rcpf_pkg::TIME_W'(cfg.command_timeout_us))) begin
         result.drive_mode = rcpf_pkg::MODE_FAILSAFE;
      end else begin
         result.drive_mode = rcpf_pkg::MODE_AUTONOMOUS;
      end
   end

endmodule

// ===== rtl/rc_pwm_capture_failsafe.sv =====
// RC PWM capture decoder with failsafe drive mode. Each request word is a capture
// edge (op 0), a velocity-command notice (op 1) or a status query (op 2 or 3), and
// every word produces exactly one response word carrying the steering and throttle
// widths in microseconds, the manual switch (mode channel above center), signal
// health and the drive mode (0 manual, 1 autonomous, 2 failsafe stop). Widths are
// measured from rising to falling capture counts at TICKS_PER_US ticks per
// microsecond and kept only when they fall inside [min_pulse_us, max_pulse_us].
// A new word is taken every clock cycle while the response side takes words. The
// result reaches the response port through a capture stage, a window and divide
// stage, and a status stage, followed by the output register. Throughput is one
// word per cycle as long as the response side takes words; the ready
// path runs from rsp_chan.ready back through the pipeline valid bits, so a
// stalled response fills the empty stages before the request side stalls.
// Configuration registers are written through the csr_ port and must only be
// changed while no word is in flight.
module rc_pwm_capture_failsafe #(
   parameter int NUM_CHANNELS = 3,
   parameter int TICKS_PER_US = 80
) (
   input  logic                               clock,
   input  logic                               reset,
   rcpf_req_if.sink                           req_chan,
   rcpf_rsp_if.source                         rsp_chan,
   input  logic                               csr_write,
   input  logic [rcpf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rcpf_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int DELTA_W = $clog2(rcpf_pkg::PULSE_RANGE * TICKS_PER_US);
   localparam int PROD_W  = 2 * DELTA_W + 2;

   // Configuration registers; a write replaces a register with the low bits of the data word.
   rcpf_pkg::cfg_type cfg_ff;
   rcpf_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            rcpf_pkg::CSR_MIN_PULSE: begin
               cfg_in.min_pulse_us = csr_wdata[rcpf_pkg::PULSE_W-1:0];
            end
            rcpf_pkg::CSR_MAX_PULSE: begin
               cfg_in.max_pulse_us = csr_wdata[rcpf_pkg::PULSE_W-1:0];
            end
            rcpf_pkg::CSR_CENTER: begin
               cfg_in.center_us = csr_wdata[rcpf_pkg::PULSE_W-1:0];
            end
            rcpf_pkg::CSR_SIGNAL_TIMEOUT: begin
               cfg_in.signal_timeout_us = csr_wdata[rcpf_pkg::TIMEOUT_W-1:0];
            end
            rcpf_pkg::CSR_COMMAND_TIMEOUT: begin
               cfg_in.command_timeout_us = csr_wdata[rcpf_pkg::TIMEOUT_W-1:0];
            end
            default: begin
               // Writes past the last register are dropped.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_pulse_us       <= rcpf_pkg::RST_MIN_PULSE;
         cfg_ff.max_pulse_us       <= rcpf_pkg::RST_MAX_PULSE;
         cfg_ff.center_us          <= rcpf_pkg::RST_CENTER;
         cfg_ff.signal_timeout_us  <= rcpf_pkg::RST_SIGNAL_TIMEOUT;
         cfg_ff.command_timeout_us <= rcpf_pkg::RST_COMMAND_TIMEOUT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Pipeline occupancy. A stage moves on when the next one is empty or moving.
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic move1, move2, move3;
   logic accept;

   assign move3  = s3_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign move2  = s2_valid_ff && (!s3_valid_ff || move3);
   assign move1  = s1_valid_ff && (!s2_valid_ff || move2);
   assign req_chan.ready = !s1_valid_ff || move1;
   assign accept = req_chan.valid && req_chan.ready;

   assign s1_valid_in  = accept ? 1'b1 : (move1 ? 1'b0 : s1_valid_ff);
   assign s2_valid_in  = move1  ? 1'b1 : (move2 ? 1'b0 : s2_valid_ff);
   assign s3_valid_in  = move2  ? 1'b1 : (move3 ? 1'b0 : s3_valid_ff);
   assign rsp_valid_in = move3  ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   rcpf_pkg::item_type    req_item;
   rcpf_pkg::capture_type cap;
   rcpf_pkg::update_type  upd;
   logic [PROD_W-1:0]     prod;
   rcpf_pkg::result_type  result;
   rcpf_pkg::result_type  result_ff;

   always_comb begin
      req_item.op            = req_chan.op;
      req_item.channel       = req_chan.channel;
      req_item.rising        = req_chan.rising;
      req_item.capture_ticks = req_chan.capture_ticks;
      req_item.now_us        = req_chan.now_us;
   end

   // Stage 1: holds the rising-edge counts and forms the tick difference.
   rcpf_capture #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_capture (
      .clock   (clock),
      .reset   (reset),
      .load    (accept),
      .advance (move1),
      .item    (req_item),
      .cap     (cap)
   );

   // Stage 2: window check in ticks and the reciprocal multiply.
   rcpf_window #(
      .TICKS_PER_US (TICKS_PER_US)
   ) u_window (
      .clock (clock),
      .load  (move1),
      .cap   (cap),
      .cfg   (cfg_ff),
      .upd   (upd),
      .prod  (prod)
   );

   // Stage 3: kept widths, timestamps, health and drive mode.
   rcpf_status #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .TICKS_PER_US (TICKS_PER_US)
   ) u_status (
      .clock   (clock),
      .reset   (reset),
      .load    (move2),
      .advance (move3),
      .upd     (upd),
      .prod    (prod),
      .cfg     (cfg_ff),
      .result  (result)
   );

   // Output register; holds the response word until the sink takes it.
   always_ff @(posedge clock) begin
      if (move3) begin
         result_ff <= result;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.steering_us   = result_ff.steering_us;
   assign rsp_chan.throttle_us   = result_ff.throttle_us;
   assign rsp_chan.manual_switch = result_ff.manual_switch;
   assign rsp_chan.link_ok       = result_ff.link_ok;
   assign rsp_chan.drive_mode    = result_ff.drive_mode;

endmodule

// ===== rtl/rcpf_checker.sv =====
module rcpf_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [rcpf_pkg::PULSE_W-1:0] steering_us,
   input logic [rcpf_pkg::PULSE_W-1:0] throttle_us,
   input logic                         manual_switch,
   input logic                         link_ok,
   input logic [1:0]                   drive_mode
);

   // A stalled response word stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(steering_us)
         && $stable(throttle_us) && $stable(manual_switch)
         && $stable(link_ok) && $stable(drive_mode))
      else $error("response word changed while stalled");

   // Manual mode exactly when the switch is up and the signal is healthy.
   a_manual_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((drive_mode == rcpf_pkg::MODE_MANUAL)
                     == (manual_switch && link_ok)))
      else $error("drive mode disagrees with manual switch and signal health");

   // No response word is left over from before reset.
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind rc_pwm_capture_failsafe rcpf_checker u_rcpf_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .steering_us   (rsp_chan.steering_us),
   .throttle_us   (rsp_chan.throttle_us),
   .manual_switch (rsp_chan.manual_switch),
   .link_ok       (rsp_chan.link_ok),
   .drive_mode    (rsp_chan.drive_mode)
);

// ===== verif/rc_pwm_capture_failsafe_tb.sv =====
`timescale 1ns / 100ps

module rc_pwm_capture_failsafe_tb;

   // The block is built with its default channel count and capture clock rate.
   localparam int NUM_CH = 3;
   localparam int TICKS = 80;

   // Field widths and channel roles as the block defines them.
   localparam int TICK_W     = rcpf_pkg::TICK_W;
   localparam int PULSE_W    = rcpf_pkg::PULSE_W;
   localparam int TIME_W     = rcpf_pkg::TIME_W;
   localparam int TIMEOUT_W  = rcpf_pkg::TIMEOUT_W;
   localparam int CSR_IDX_W  = rcpf_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = rcpf_pkg::CSR_DATA_W;
   localparam logic [1:0] CH_STEERING = 2'(rcpf_pkg::CH_STEERING);
   localparam logic [1:0] CH_THROTTLE = 2'(rcpf_pkg::CH_THROTTLE);
   localparam logic [1:0] CH_MODE     = 2'(rcpf_pkg::CH_MODE);

   // Codes outside the decoded ranges. An unused op acts as a status query, and a
   // capture on an unused channel is ignored. Indexes above the last register are
   // spare and must not disturb anything.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [1:0] CH_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LOW = 3'd5;

   // The pipeline is four registers deep, so a few idle cycles after the last
   // response are enough to catch a stray extra word.
   localparam int DRAIN_CYCLES = 8;
   localparam int LIMIT_CYCLES = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rcpf_req_if req_bus ();
   rcpf_rsp_if rsp_bus ();

   rc_pwm_capture_failsafe #(
      .NUM_CHANNELS(NUM_CH),
      .TICKS_PER_US(TICKS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // Our own copy of the decoder state. Each channel remembers the count of its
   // last rising edge, its last accepted width, when that width was accepted, and
   // whether any width was accepted at all. The command side keeps one timestamp.
   logic [TICK_W-1:0] rise_mark [NUM_CH];
   logic [PULSE_W-1:0] kept_width [NUM_CH];
   logic [TIME_W-1:0] kept_stamp [NUM_CH];
   logic kept_valid [NUM_CH];
   logic [TIME_W-1:0] cmd_stamp;
   logic cmd_valid;
   rcpf_pkg::cfg_type live_cfg;

   // Status words we expect back, oldest first.
   rcpf_pkg::result_type status_q [$];

   // Current system time handed to the block with every word.
   logic [TIME_W-1:0] clock_us;

   // When set, neither side inserts idle cycles, so the block runs at full rate.
   bit calm = 1'b0;

   int error_count = 0;
   int cycle_count = 0;

   function automatic rcpf_pkg::cfg_type make_cfg(input logic [PULSE_W-1:0] lo,
                                                  input logic [PULSE_W-1:0] hi,
                                                  input logic [PULSE_W-1:0] mid,
                                                  input logic [TIMEOUT_W-1:0] sig,
                                                  input logic [TIMEOUT_W-1:0] cmd);
      rcpf_pkg::cfg_type c;
      c.min_pulse_us = lo;
      c.max_pulse_us = hi;
      c.center_us = mid;
      c.signal_timeout_us = sig;
      c.command_timeout_us = cmd;
      return c;
   endfunction

   // Applies one accepted request word to the state copy and returns the status
   // word the block must answer with. The status is computed after the update.
   function automatic rcpf_pkg::result_type predict_status(input logic [1:0] op,
                                                           input logic [1:0] ch,
                                                           input logic rising,
                                                           input logic [TICK_W-1:0] ticks,
                                                           input logic [TIME_W-1:0] now);
      logic [TICK_W-1:0] span;
      logic [TICK_W-1:0] width_us;
      logic [TIME_W-1:0] age;
      logic alive;
      rcpf_pkg::result_type r;
      alive = 1'b0;
      if (op == rcpf_pkg::OP_CAPTURE && ch < NUM_CH) begin
         if (rising) begin
            rise_mark[ch] = ticks;
         end else begin
            // The capture counter is free running, so the span wraps modulo 2^32.
            span = ticks - rise_mark[ch];
            width_us = span / TICKS;
            if (width_us >= live_cfg.min_pulse_us && width_us <= live_cfg.max_pulse_us) begin
               kept_width[ch] = width_us[PULSE_W-1:0];
               kept_stamp[ch] = now;
               kept_valid[ch] = 1'b1;
            end
         end
      end else if (op == rcpf_pkg::OP_COMMAND) begin
         cmd_stamp = now;
         cmd_valid = 1'b1;
      end
      // Ages are taken modulo 2^48, so a time that wrapped still gives a small age.
      for (int i = 0; i < NUM_CH; i++) begin
         age = now - kept_stamp[i];
         if (kept_valid[i] && age < live_cfg.signal_timeout_us)
            alive = 1'b1;
      end
      r.steering_us = kept_width[CH_STEERING];
      r.throttle_us = kept_width[CH_THROTTLE];
      r.manual_switch = kept_width[CH_MODE] > live_cfg.center_us;
      r.link_ok = alive;
      age = now - cmd_stamp;
      if (r.manual_switch && alive)
         r.drive_mode = rcpf_pkg::MODE_MANUAL;
      else if (!cmd_valid || age > live_cfg.command_timeout_us)
         r.drive_mode = rcpf_pkg::MODE_FAILSAFE;
      else
         r.drive_mode = rcpf_pkg::MODE_AUTONOMOUS;
      return r;
   endfunction

   // Prints one line for each mismatch and counts it.
   task automatic report_mismatch(input string what, input logic [TIME_W-1:0] want,
                                  input logic [TIME_W-1:0] got);
      $display("cycle %0d: %s: expected %0d, got %0d", cycle_count, what, want, got);
      error_count++;
   endtask

   // Sends one request word. The sender first idles for a random number of cycles,
   // then holds valid until the block takes the word. The expectation is formed at
   // the accepting edge, so the state copy follows the order the block sees.
   task automatic send_word(input logic [1:0] op, input logic [1:0] ch, input logic rising,
                            input logic [TICK_W-1:0] ticks, input logic [TIME_W-1:0] now);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.op <= op;
      req_bus.channel <= ch;
      req_bus.rising <= rising;
      req_bus.capture_ticks <= ticks;
      req_bus.now_us <= now;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      status_q.push_back(predict_status(op, ch, rising, ticks, now));
   endtask

   // A rising edge followed by a falling edge on the same channel.
   task automatic send_pulse(input logic [1:0] ch, input logic [TICK_W-1:0] start,
                             input logic [TICK_W-1:0] span);
      send_word(rcpf_pkg::OP_CAPTURE, ch, 1'b1, start, clock_us);
      send_word(rcpf_pkg::OP_CAPTURE, ch, 1'b0, start + span, clock_us);
   endtask

   // Queries and commands carry random junk in the fields they do not use.
   task automatic send_query(input logic [TIME_W-1:0] now);
      send_word(rcpf_pkg::OP_QUERY, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                $urandom, now);
   endtask

   task automatic send_command(input logic [TIME_W-1:0] now);
      send_word(rcpf_pkg::OP_COMMAND, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                $urandom, now);
   endtask

   // Stops sending and waits until every expected status word has come back,
   // then lets the pipeline run empty for a few cycles.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (status_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes every register once the block is idle. A spare index is written
   // first with random data, and the unused upper bits of the 12-bit registers
   // carry junk; neither may change the configuration.
   task automatic apply_config(input rcpf_pkg::cfg_type c);
      logic [31:0] junk;
      settle();
      junk = $urandom;
      csr_write <= 1'b1;
      csr_index <= CSR_SPARE_LOW + CSR_IDX_W'($urandom_range(0, 2));
      csr_wdata <= junk[CSR_DATA_W-1:0];
      @(posedge clock);
      junk = $urandom;
      csr_index <= rcpf_pkg::CSR_MIN_PULSE;
      csr_wdata <= {junk[11:0], c.min_pulse_us};
      @(posedge clock);
      csr_index <= rcpf_pkg::CSR_MAX_PULSE;
      csr_wdata <= {junk[23:12], c.max_pulse_us};
      @(posedge clock);
      csr_index <= rcpf_pkg::CSR_CENTER;
      csr_wdata <= {junk[31:20], c.center_us};
      @(posedge clock);
      csr_index <= rcpf_pkg::CSR_SIGNAL_TIMEOUT;
      csr_wdata <= c.signal_timeout_us;
      @(posedge clock);
      csr_index <= rcpf_pkg::CSR_COMMAND_TIMEOUT;
      csr_wdata <= c.command_timeout_us;
      @(posedge clock);
      csr_write <= 1'b0;
      live_cfg = c;
   endtask

   // Random traffic. Most of it is complete pulses with widths drawn around the
   // window edges, the center and inside the window, mixed with commands and
   // queries. The rest is noise with every field random. Time moves forward by
   // up to pace microseconds per step, and now and then jumps right onto one of
   // the timeouts so that the strict and inclusive comparisons are both hit.
   task automatic run_traffic(input int unsigned words, input int unsigned pace);
      int unsigned sent;
      int unsigned pick;
      int unsigned w;
      logic [TICK_W-1:0] span;
      logic [63:0] rnd;
      sent = 0;
      while (sent < words) begin
         if ($urandom_range(0, 40) == 0)
            calm = ($urandom_range(0, 2) == 0);
         if ($urandom_range(0, 15) == 0) begin
            if ($urandom_range(0, 1) == 0)
               clock_us = clock_us + TIME_W'(live_cfg.signal_timeout_us)
                          + TIME_W'($urandom_range(0, 2)) - 48'd1;
            else
               clock_us = clock_us + TIME_W'(live_cfg.command_timeout_us)
                          + TIME_W'($urandom_range(0, 2)) - 48'd1;
         end else begin
            clock_us = clock_us + TIME_W'($urandom_range(0, pace));
         end
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            case ($urandom_range(0, 6))
               0: w = live_cfg.min_pulse_us + $urandom_range(0, 2) - 1;
               1: w = live_cfg.max_pulse_us + $urandom_range(0, 2) - 1;
               2: w = live_cfg.center_us + $urandom_range(0, 2) - 1;
               3: w = $urandom_range(0, rcpf_pkg::PULSE_RANGE - 1);
               default: begin
                  if (live_cfg.min_pulse_us <= live_cfg.max_pulse_us)
                     w = $urandom_range(live_cfg.min_pulse_us, live_cfg.max_pulse_us);
                  else
                     w = $urandom_range(0, rcpf_pkg::PULSE_RANGE - 1);
               end
            endcase
            span = w * TICKS + $urandom_range(0, TICKS - 1);
            if ($urandom_range(0, 19) == 0)
               span = $urandom;
            send_pulse(2'($urandom_range(0, NUM_CH - 1)), $urandom, span);
            sent += 2;
         end else if (pick < 70) begin
            send_command(clock_us);
            sent++;
         end else if (pick < 82) begin
            send_query(clock_us);
            sent++;
         end else begin
            rnd = {$urandom, $urandom};
            if ($urandom_range(0, 3) == 0)
               clock_us = rnd[TIME_W-1:0];
            send_word(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1)), $urandom, clock_us);
            sent++;
         end
      end
      calm = 1'b0;
   endtask

   // Straight out of reset: center widths, no signal, no command, so failsafe.
   // The unused op must answer the same way, here at the top of the time range.
   task automatic test_reset_state();
      clock_us = '0;
      send_word(rcpf_pkg::OP_QUERY, CH_STEERING, 1'b0, '0, clock_us);
      send_word(OP_UNUSED, CH_MODE, 1'b1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
   endtask

   // Width measurement and the acceptance window at the reset settings.
   task automatic test_pulse_window();
      clock_us = 48'h0000_0010_0000;
      // A falling edge with no rising edge measures from the reset count of zero.
      send_word(rcpf_pkg::OP_CAPTURE, CH_THROTTLE, 1'b0, 1000 * TICKS + 79, clock_us);
      // The counter wraps inside this pulse, and the width lands exactly on the minimum.
      send_pulse(CH_STEERING, 32'hFFFF_F000, 800 * TICKS);
      send_pulse(CH_STEERING, 32'h1234_5678, 2200 * TICKS + 79);
      // One microsecond outside either end of the window is dropped.
      send_pulse(CH_STEERING, 32'h0000_0100, 800 * TICKS - 1);
      send_pulse(CH_STEERING, 32'h8000_0000, 2201 * TICKS);
      // The switch needs a width strictly above center.
      send_pulse(CH_MODE, 32'h5555_AAAA, 1501 * TICKS);
      send_pulse(CH_MODE, 32'hAAAA_5555, 1500 * TICKS);
      // Edges on a channel that does not exist are ignored.
      send_word(rcpf_pkg::OP_CAPTURE, CH_UNUSED, 1'b0, 32'h0001_0000, clock_us);
   endtask

   // Timeout boundaries and time wrap. Every edge above was kept at one instant.
   task automatic test_timeouts();
      logic [TIME_W-1:0] mark;
      mark = clock_us;
      apply_config(make_cfg(rcpf_pkg::RST_MIN_PULSE, rcpf_pkg::RST_MAX_PULSE,
                            rcpf_pkg::RST_CENTER, 24'd100, 24'd50));
      send_query(mark + 99);
      send_query(mark + 100);
      clock_us = mark + 1000;
      send_command(clock_us);
      send_query(clock_us + 50);
      send_query(clock_us + 51);
      // The command is stamped just below the wrap; the query comes after it.
      clock_us = 48'hFFFF_FFFF_FFEC;
      send_command(clock_us);
      send_query(clock_us + 30);
   endtask

   // Full window with a zero center, then an inverted window with zero timeouts.
   task automatic test_window_extremes();
      apply_config(make_cfg('0, '1, '0, '1, '1));
      clock_us += 5;
      send_pulse(CH_MODE, $urandom, 0);
      send_pulse(CH_THROTTLE, $urandom, 4095 * TICKS + 79);
      send_pulse(CH_STEERING, $urandom, 4096 * TICKS);
      apply_config(make_cfg(12'd2000, 12'd1000, 12'd1000, '0, '0));
      send_pulse(CH_STEERING, $urandom, 1500 * TICKS);
      // With a zero command timeout only a command of age zero keeps autonomy.
      send_command(clock_us);
      send_query(clock_us);
      send_query(clock_us + 1);
   endtask

   task automatic test_default_traffic();
      apply_config(make_cfg(rcpf_pkg::RST_MIN_PULSE, rcpf_pkg::RST_MAX_PULSE,
                            rcpf_pkg::RST_CENTER, rcpf_pkg::RST_SIGNAL_TIMEOUT,
                            rcpf_pkg::RST_COMMAND_TIMEOUT));
      run_traffic(350, 20000);
   endtask

   // Short timeouts so that signal loss and failsafe toggle often.
   task automatic test_tight_timeouts();
      apply_config(make_cfg(rcpf_pkg::RST_MIN_PULSE, rcpf_pkg::RST_MAX_PULSE,
                            PULSE_W'($urandom_range(1000, 2000)),
                            TIMEOUT_W'($urandom_range(50, 3000)),
                            TIMEOUT_W'($urandom_range(50, 3000))));
      run_traffic(350, 800);
   endtask

   // Fully random settings; the window is put in order half the time so that
   // widths still get through.
   task automatic test_random_settings();
      logic [PULSE_W-1:0] lo;
      logic [PULSE_W-1:0] hi;
      logic [PULSE_W-1:0] swap;
      logic [31:0] sig;
      logic [31:0] cmd;
      for (int round = 0; round < 4; round++) begin
         lo = PULSE_W'($urandom);
         hi = PULSE_W'($urandom);
         if ($urandom_range(0, 1) == 0 && lo > hi) begin
            swap = lo;
            lo = hi;
            hi = swap;
         end
         sig = $urandom;
         cmd = $urandom;
         apply_config(make_cfg(lo, hi, PULSE_W'($urandom), sig[23:0], cmd[23:0]));
         run_traffic(100, (sig[23:0] < cmd[23:0] ? sig[23:0] : cmd[23:0]) / 2 + 1);
      end
   endtask

   // The register extremes: widest window with the switch unreachable and the longest
   // timeouts, then an inverted window with a zero signal timeout and a command timeout of one.
   task automatic test_extreme_settings();
      apply_config(make_cfg('0, '1, '1, '1, '1));
      run_traffic(150, 3000000);
      apply_config(make_cfg('1, '0, '0, '0, 24'd1));
      run_traffic(150, 3);
   endtask

   // Response side: stall for a random number of cycles before each word, except
   // in calm stretches where ready stays high.
   initial begin : response_stalls
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 3);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1));
      end
   end

   // Every accepted status word is compared field by field with the oldest
   // expectation. A word with nothing expected is an error on its own.
   always @(posedge clock) begin : check_words
      rcpf_pkg::result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (status_q.size() == 0) begin
            report_mismatch("status word with nothing expected", '0, '0);
         end else begin
            want = status_q.pop_front();
            if (rsp_bus.steering_us !== want.steering_us)
               report_mismatch("steering_us", TIME_W'(want.steering_us),
                               TIME_W'(rsp_bus.steering_us));
            if (rsp_bus.throttle_us !== want.throttle_us)
               report_mismatch("throttle_us", TIME_W'(want.throttle_us),
                               TIME_W'(rsp_bus.throttle_us));
            if (rsp_bus.manual_switch !== want.manual_switch)
               report_mismatch("manual_switch", TIME_W'(want.manual_switch),
                               TIME_W'(rsp_bus.manual_switch));
            if (rsp_bus.link_ok !== want.link_ok)
               report_mismatch("link_ok", TIME_W'(want.link_ok), TIME_W'(rsp_bus.link_ok));
            if (rsp_bus.drive_mode !== want.drive_mode)
               report_mismatch("drive_mode", TIME_W'(want.drive_mode),
                               TIME_W'(rsp_bus.drive_mode));
         end
      end
   end

   // A hung handshake or a lost word ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = rcpf_pkg::CSR_MIN_PULSE;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.op = rcpf_pkg::OP_QUERY;
      req_bus.channel = CH_STEERING;
      req_bus.rising = 1'b0;
      req_bus.capture_ticks = '0;
      req_bus.now_us = '0;
      rsp_bus.ready = 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
         rise_mark[i] = '0;
         kept_width[i] = rcpf_pkg::RST_CENTER;
         kept_stamp[i] = '0;
         kept_valid[i] = 1'b0;
      end
      cmd_stamp = '0;
      cmd_valid = 1'b0;
      live_cfg = make_cfg(rcpf_pkg::RST_MIN_PULSE, rcpf_pkg::RST_MAX_PULSE,
                          rcpf_pkg::RST_CENTER, rcpf_pkg::RST_SIGNAL_TIMEOUT,
                          rcpf_pkg::RST_COMMAND_TIMEOUT);
      clock_us = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_pulse_window();
      test_timeouts();
      test_window_extremes();
      test_default_traffic();
      test_tight_timeouts();
      test_random_settings();
      test_extreme_settings();

      settle();
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== rc_pwm_capture_failsafe.f =====
rtl/rcpf_pkg.sv
rtl/rcpf_req_if.sv
rtl/rcpf_rsp_if.sv
rtl/rcpf_capture.sv
rtl/rcpf_window.sv
rtl/rcpf_status.sv
rtl/rc_pwm_capture_failsafe.sv
rtl/rcpf_checker.sv
verif/rc_pwm_capture_failsafe_tb.sv
